// File: hdl/srq_pkg.sv
// package with shared types and constants of the sorted ready queue
`timescale 1ns / 1ps

package srq_pkg;

  localparam int Depth  = 16;
  localparam int CountW = $clog2(Depth + 1);
  localparam int KeyW   = 32;
  localparam int IdW    = 16;
  localparam int CntOutW = 5;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_SORTED = 2'd1,
    KIND_POP    = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [IdW-1:0]         id;
  } entry_t;

  typedef struct packed {
    logic   ins;     // append or sorted insert, queue not full
    logic   sorted;  // insert by key
    logic   rem;     // pop or remove by id
    logic   pop;     // remove takes the head
    entry_t item;
  } cmd_t;

endpackage

// File: hdl/srq_cell.sv
// one queue cell: holds an entry and shifts it to or from its neighbors
`timescale 1ns / 1ps

module srq_cell (
  input  logic           clk_i,
  input  srq_pkg::cmd_t  cmd_i,
  input  logic           occ_i,
  input  logic           found_i,
  input  srq_pkg::entry_t left_i,
  input  srq_pkg::entry_t right_i,
  output srq_pkg::entry_t entry_o,
  output logic           found_o,
  output logic           first_o
);
  import srq_pkg::*;

  entry_t entry_q, entry_d;
  logic   match;

  always_comb begin
    if (cmd_i.ins) begin
      match = !occ_i || (cmd_i.sorted && (cmd_i.item.key < entry_q.key));
    end else begin
      match = occ_i && (cmd_i.pop || (cmd_i.item.id == entry_q.id));
    end
  end

  assign found_o = found_i || match;
  assign first_o = match && !found_i;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (found_i) begin
        entry_d = left_i;
      end else if (match) begin
        entry_d = cmd_i.item;
      end
    end else if (cmd_i.rem && found_o) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hdl/sorted_ready_queue.sv
// top level of the sorted ready queue: chain of cells and result register
`timescale 1ns / 1ps

// Ordered queue of up to Depth entries (task id, signed key) held in a row of
// cells, head in cell 0. Each input transaction carries one operation in tuser:
// append at tail, sorted insert after all keys less than or equal, pop head, or
// remove the first entry with a matching id. Every cell compares in parallel and
// the whole row shifts in the same cycle, at the clock edge that accepts the operation.
// Each input transaction produces exactly one output transaction, available from
// the output register in the cycle after acceptance, with the removed entry, flags
// and the new count. Throughput is 1 transaction per cycle while results are taken;
// it is set by the cell row updating on acceptance and the one-entry output register.
// When the receiver stalls, the result waits in the output register and the
// input is still taken in the cycle the waiting result is taken.
// Reset empties the queue (count zero) and drops any pending result; cell
// contents are not cleared and are only read once written.
// An insert into a full queue leaves it unchanged and sets the reject flag.

module sorted_ready_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // item_key[31:0], item_id[47:32]
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // out_id[15:0], out_key[47:16], entry_count[52:48]
  output logic [1:0]  m_axis_tuser_o    // out_valid[0], full_reject[1]
);
  import srq_pkg::*;

  logic              s_acc;
  kind_e             kind;
  cmd_t              cmd;
  logic              full;
  logic [CountW-1:0] count_q, count_d;
  logic [Depth:0]    found;
  logic [Depth-1:0]  first;
  logic [Depth-1:0]  occ;
  entry_t            cells [Depth];
  entry_t            res_entry;
  logic              res_valid;

  logic              m_valid_q;
  logic              out_valid_q;
  logic              reject_q;
  entry_t            out_entry_q;
  logic [CntOutW-1:0] out_count_q;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign kind  = kind_e'(s_axis_tuser_i);
  assign full  = (count_q == CountW'(Depth));

  always_comb begin
    cmd.item.key = s_axis_tdata_i[31:0];
    cmd.item.id  = s_axis_tdata_i[47:32];
    cmd.ins      = 1'b0;
    cmd.sorted   = 1'b0;
    cmd.rem      = 1'b0;
    cmd.pop      = 1'b0;
    case (kind)
      KIND_APPEND: cmd.ins = s_acc && !full;
      KIND_SORTED: begin
        cmd.ins    = s_acc && !full;
        cmd.sorted = 1'b1;
      end
      KIND_POP: begin
        cmd.rem = s_acc;
        cmd.pop = 1'b1;
      end
      KIND_REMOVE: cmd.rem = s_acc;
      default: cmd.ins = 1'b0;
    endcase
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    entry_t left_n, right_n;
    assign occ[i] = (CountW'(i) < count_q);
    if (i == 0) begin : g_head
      assign left_n = cmd.item;
    end else begin : g_mid
      assign left_n = cells[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right_n = '0;
    end else begin : g_body
      assign right_n = cells[i+1];
    end
    srq_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .occ_i   (occ[i]),
      .found_i (found[i]),
      .left_i  (left_n),
      .right_i (right_n),
      .entry_o (cells[i]),
      .found_o (found[i+1]),
      .first_o (first[i])
    );
  end

  always_comb begin
    res_entry = '0;
    for (int i = 0; i < Depth; i++) begin
      if (first[i]) begin
        res_entry = res_entry | cells[i];
      end
    end
    if (!cmd.rem) begin
      res_entry = '0;
    end
  end

  assign res_valid = cmd.rem && found[Depth];

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CountW'(1);
    end else if (res_valid) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_acc) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      out_valid_q <= res_valid;
      reject_q    <= (kind == KIND_APPEND || kind == KIND_SORTED) && full;
      out_entry_q <= res_entry;
      out_count_q <= CntOutW'(count_d);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_count_q, out_entry_q.key, out_entry_q.id};
  assign m_axis_tuser_o  = {reject_q, out_valid_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("queue count beyond depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q == $past(count_q) + CountW'(1))
    else $error("insert did not grow the queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && kind == KIND_POP && count_q != '0) |=>
      (out_valid_q && count_q == $past(count_q) - CountW'(1)))
    else $error("pop of a filled queue returned nothing");

  a_reject_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && reject_q) |-> !out_valid_q)
    else $error("reject and entry flagged together");

endmodule

// File: dv/sorted_ready_queue_test.sv
// self-checking testbench of the sorted ready queue with its own queue predictor
`timescale 1ns / 1ps

module sorted_ready_queue_test;
  import srq_pkg::*;

  localparam int StallLimit = 2000;

  typedef struct packed {
    logic               valid;
    logic               reject;
    logic [IdW-1:0]     id;
    logic [KeyW-1:0]    key;
    logic [CntOutW-1:0] count;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;   // item_key[31:0], item_id[47:32]
  logic [1:0]  s_axis_tuser_i;   // kind[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [55:0] m_axis_tdata_o;   // out_id[15:0], out_key[47:16], entry_count[52:48]
  logic [1:0]  m_axis_tuser_o;   // out_valid[0], full_reject[1]

  entry_t   held[$];
  outcome_t expected_outcomes[$];
  bit       idle_on = 1'b1;
  int       mismatches = 0;
  int       results_seen = 0;
  int       op_count[4] = '{0, 0, 0, 0};
  int       rejects = 0;
  int       entries_returned = 0;
  int       peak = 0;
  int       quiet_cycles = 0;

  sorted_ready_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // queue contents after one operation and the transaction it should return
  function automatic outcome_t predict_queue_op(kind_e op, logic [KeyW-1:0] key,
                                                logic [IdW-1:0] id);
    outcome_t res;
    entry_t   e;
    int       slot;
    bit       found;
    res = '0;
    e.key = key;
    e.id = id;
    found = 1'b0;
    case (op)
      KIND_APPEND, KIND_SORTED: begin
        if (held.size() >= Depth) begin
          res.reject = 1'b1;
        end else begin
          slot = held.size();
          if (op == KIND_SORTED) begin
            for (int i = held.size() - 1; i >= 0; i--) begin
              if ($signed(key) < $signed(held[i].key)) slot = i;
            end
          end
          held.insert(slot, e);
        end
      end
      KIND_POP: begin
        if (held.size() > 0) begin
          res.valid = 1'b1;
          res.id = held[0].id;
          res.key = held[0].key;
          held.delete(0);
        end
      end
      default: begin
        for (int i = 0; i < held.size(); i++) begin
          if (!found && held[i].id == id) begin
            found = 1'b1;
            slot = i;
          end
        end
        if (found) begin
          res.valid = 1'b1;
          res.id = held[slot].id;
          res.key = held[slot].key;
          held.delete(slot);
        end
      end
    endcase
    res.count = CntOutW'(held.size());
    return res;
  endfunction

  function automatic logic [KeyW-1:0] random_key();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return KeyW'($urandom_range(0, 16)) - KeyW'(8);  // crowded keys for ties
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IdW-1:0] random_id();
    if ($urandom_range(0, 1) == 0) return IdW'($urandom_range(0, 15));
    return IdW'($urandom_range(0, 65535));
  endfunction

  // entered and left at a falling edge; valid stays high between back-to-back items
  task automatic send_op(kind_e op, logic [KeyW-1:0] key, logic [IdW-1:0] id);
    outcome_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {id, key};
    s_axis_tuser_i <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = predict_queue_op(op, key, id);
    expected_outcomes.push_back(res);
    op_count[int'(op)]++;
    if (res.reject) rejects++;
    if (res.valid) entries_returned++;
    if (held.size() > peak) peak = held.size();
    @(negedge clk_i);
  endtask

  task automatic send_random(int insert_pct);
    kind_e           op;
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  id;
    key = random_key();
    id = random_id();
    if ($urandom_range(0, 99) < insert_pct) begin
      op = ($urandom_range(0, 2) == 0) ? KIND_APPEND : KIND_SORTED;
    end else begin
      op = ($urandom_range(0, 1) == 0) ? KIND_POP : KIND_REMOVE;
      // mostly remove an id that is really queued
      if (op == KIND_REMOVE && held.size() > 0 && $urandom_range(0, 9) < 7) begin
        id = held[$urandom_range(0, held.size() - 1)].id;
      end
    end
    send_op(op, key, id);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_op(KIND_POP, '0, '0);
    send_op(KIND_REMOVE, 32'hffff_ffff, 16'hffff);
  endtask

  task automatic test_sorted_order();
    send_op(KIND_SORTED, 32'h7fff_ffff, 16'hffff);
    send_op(KIND_SORTED, 32'h8000_0000, 16'h0000);
    send_op(KIND_SORTED, 32'd5, 16'd1);
    send_op(KIND_SORTED, 32'd5, 16'd2);
    send_op(KIND_SORTED, 32'hffff_ffff, 16'd3);
    send_op(KIND_APPEND, 32'd0, 16'd4);
    send_op(KIND_REMOVE, '0, 16'd2);   // middle entry
    send_op(KIND_REMOVE, '0, 16'd4);   // tail entry
    send_op(KIND_REMOVE, '0, 16'd9);   // no match
    send_op(KIND_SORTED, 32'd5, 16'd5);
    send_op(KIND_POP, '0, '0);
  endtask

  task automatic test_full_queue();
    while (held.size() < Depth) send_op(KIND_SORTED, random_key(), random_id());
    send_op(KIND_APPEND, 32'h1234_5678, 16'h5555);
    send_op(KIND_SORTED, 32'h8000_0000, 16'haaaa);
    send_op(KIND_POP, '0, '0);
  endtask

  task automatic test_random_traffic(int n);
    int pct;
    pct = 50;
    for (int i = 0; i < n; i++) begin
      // change the mix now and then so the queue swings between empty and full
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: pct = 25;
          1: pct = 50;
          default: pct = 75;
        endcase
      end
      send_random(pct);
    end
  endtask

  task automatic test_pause_for_drain();
    test_random_traffic(100);
    wait_drained();
    test_random_traffic(100);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_traffic(400);
  endtask

  // receiver stalls
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s at result %0d: expected %0h, got %0h",
                 name, results_seen, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %h/%h arrived with no transaction pending",
                   m_axis_tuser_o, m_axis_tdata_o);
        end
      end else begin
        want = expected_outcomes.pop_front();
        check_field("out_valid", want.valid, m_axis_tuser_o[0]);
        check_field("full_reject", want.reject, m_axis_tuser_o[1]);
        check_field("out_id", want.id, m_axis_tdata_o[15:0]);
        check_field("out_key", want.key, m_axis_tdata_o[47:16]);
        check_field("entry_count", want.count, m_axis_tdata_o[52:48]);
        check_field("tdata padding", '0, m_axis_tdata_o[55:53]);
      end
      results_seen++;
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no transaction for %0d cycles", StallLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = KIND_APPEND;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_queue();
    test_sorted_order();
    test_full_queue();
    test_random_traffic(1300);
    test_pause_for_drain();
    test_full_rate();

    s_axis_tvalid_i <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    check_field("pending results", '0, expected_outcomes.size());

    $display("%0d transactions: %0d append, %0d sorted insert, %0d pop, %0d remove",
             results_seen, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("%0d refused when full, %0d entries returned, peak occupancy %0d, %0d mismatches",
             rejects, entries_returned, peak, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
